>>> src/polyphase_interpolating_fir_assert.svh
// Assertion macros used by the polyphase interpolator RTL.
`ifndef POLYPHASE_INTERPOLATING_FIR_ASSERT_SVH
`define POLYPHASE_INTERPOLATING_FIR_ASSERT_SVH

`ifndef SYNTH

// Plain property, checked every clock outside reset.
`define PIF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("polyphase fir check failed");

// Same-cycle implication.
`define PIF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("polyphase fir check failed");

// Next-cycle implication.
`define PIF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("polyphase fir check failed");

`else

`define PIF_ASSERT(lbl, clk, rst_n, prop)
`define PIF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PIF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> src/pif_pkg.sv
// Shared types and constants of the polyphase interpolating FIR.
package pif_pkg;

  localparam int unsigned DEF_MAX_TAPS   = 64;
  localparam int unsigned DEF_MAX_INTERP = 8;
  localparam int unsigned DEF_SAMPLE_W   = 16;

  // Q1.15 coefficients
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned COEF_FRAC = 15;

  localparam int unsigned CFG_ADDR_W = 1;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_TAP    = 1'b1
  } req_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_INTERP    = 1'b0,
    REG_TAP_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_WAIT,
    S_EMIT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_en;  // write zero to both stores at cmd_addr
    logic smp_we;    // push the input sample into the delay line
    logic tap_we;    // write the input coefficient
    logic issue;     // read one tap/sample pair into the MAC pipe
    logic acc_clr;   // clear the accumulator
    logic emit;      // load the rounded sum into the output register
    logic last;      // emitted word is the last phase of the run
  } cmd_t;

  // Width of the config write data: wide enough for either register
  function automatic int unsigned cfg_width(input int unsigned max_taps,
                                            input int unsigned max_interp);
    int unsigned wt;
    int unsigned wi;
    wt = $clog2(max_taps + 1);
    wi = $clog2(max_interp + 1);
    return (wt > wi) ? wt : wi;
  endfunction

endpackage

>>> src/pif_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pif_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/pif_ctrl.sv
// Sequencer: config registers, clearing pass and per-phase tap walk.
`include "polyphase_interpolating_fir_assert.svh"

module pif_ctrl #(
  parameter int unsigned MAX_TAPS   = pif_pkg::DEF_MAX_TAPS,
  parameter int unsigned MAX_INTERP = pif_pkg::DEF_MAX_INTERP,
  localparam int unsigned TIW   = $clog2(MAX_TAPS),
  localparam int unsigned PH_W  = $clog2(MAX_INTERP),
  localparam int unsigned CFG_W = pif_pkg::cfg_width(MAX_TAPS, MAX_INTERP)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input word handshake
  input  logic                        in_valid_i,
  input  pif_pkg::req_e               in_kind_i,
  output logic                        in_ready_o,
  // config writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pif_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]            cfg_wdata_i,
  // datapath
  input  logic                        out_free_i,
  output pif_pkg::cmd_t               cmd_o,
  output logic [TIW-1:0]              cmd_addr_o,
  output logic [TIW-1:0]              cmd_koff_o,
  output logic [PH_W-1:0]             cmd_phase_o
);

  import pif_pkg::*;

  localparam int unsigned INTERP_W = $clog2(MAX_INTERP + 1);
  localparam int unsigned TCNT_W   = $clog2(MAX_TAPS + 1);
  localparam int unsigned T_W      = $clog2(MAX_TAPS + MAX_INTERP + 1);

  state_e              state_q, state_d;
  logic [INTERP_W-1:0] interp_q;
  logic [TCNT_W-1:0]   tcnt_q;
  logic [INTERP_W-1:0] l_eff;
  logic [TCNT_W-1:0]   nt_eff;
  logic [T_W-1:0]      t_q, t_d;
  logic [TIW-1:0]      k_q, k_d;
  logic [PH_W-1:0]     p_q, p_d;
  logic [TIW-1:0]      clr_q, clr_d;
  logic                in_acc;
  logic                term_left;
  logic                last_ph;
  logic                clr_done;

  // Config registers; writes land any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_q <= INTERP_W'(1);
      tcnt_q   <= TCNT_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_INTERP:    interp_q <= cfg_wdata_i[INTERP_W-1:0];
        REG_TAP_COUNT: tcnt_q   <= cfg_wdata_i[TCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp factor to 1..MAX_INTERP and tap count to MAX_TAPS
  assign l_eff  = (interp_q == '0) ? INTERP_W'(1) :
                  (interp_q > INTERP_W'(MAX_INTERP)) ? INTERP_W'(MAX_INTERP) : interp_q;
  assign nt_eff = (tcnt_q > TCNT_W'(MAX_TAPS)) ? TCNT_W'(MAX_TAPS) : tcnt_q;

  assign in_acc    = in_ready_o && in_valid_i;
  assign term_left = t_q < T_W'(nt_eff);
  assign last_ph   = p_q == PH_W'(l_eff - INTERP_W'(1));
  assign clr_done  = clr_q == TIW'(MAX_TAPS - 1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_done) state_d = S_IDLE;
      S_IDLE:  if (in_acc && in_kind_i == REQ_SAMPLE) state_d = S_RUN;
      S_RUN:   if (!term_left) state_d = S_WAIT;
      S_WAIT:  state_d = S_EMIT;
      S_EMIT: begin
        if (out_free_i) state_d = last_ph ? S_IDLE : S_RUN;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // Outputs to handshake and datapath
  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_addr_o   = t_q[TIW-1:0];
    cmd_koff_o   = k_q;
    cmd_phase_o  = p_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        cmd_addr_o     = clr_q;
      end
      S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.smp_we   = in_valid_i && in_kind_i == REQ_SAMPLE;
        cmd_o.tap_we   = in_valid_i && in_kind_i == REQ_TAP;
        cmd_o.acc_clr  = in_valid_i && in_kind_i == REQ_SAMPLE;
      end
      S_RUN:  cmd_o.issue = term_left;
      S_WAIT: ;
      S_EMIT: begin
        cmd_o.emit    = out_free_i;
        cmd_o.acc_clr = out_free_i;
        cmd_o.last    = last_ph;
      end
      default: ;
    endcase
  end

  // Tap, delay and phase counters
  always_comb begin
    t_d   = t_q;
    k_d   = k_q;
    p_d   = p_q;
    clr_d = clr_q;
    case (state_q)
      S_CLEAR: clr_d = clr_q + TIW'(1);
      S_IDLE: begin
        t_d = '0;
        k_d = '0;
        p_d = '0;
      end
      S_RUN: begin
        if (term_left) begin
          t_d = t_q + T_W'(l_eff);
          k_d = k_q + TIW'(1);
        end
      end
      S_WAIT: ;
      S_EMIT: begin
        if (out_free_i && !last_ph) begin
          p_d = p_q + PH_W'(1);
          t_d = T_W'(p_q) + T_W'(1);
          k_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      t_q     <= '0;
      k_q     <= '0;
      p_q     <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      t_q     <= t_d;
      k_q     <= k_d;
      p_q     <= p_d;
      clr_q   <= clr_d;
    end
  end

  // A result is never loaded over an untaken word
  `PIF_ASSERT_IMP(a_emit_free, clk_i, rst_ni, cmd_o.emit, out_free_i)
  // The last phase ends the run
  `PIF_ASSERT_NXT(a_last_idle, clk_i, rst_ni, cmd_o.emit && cmd_o.last, state_q == S_IDLE)
  // Phase stays below the factor while a run is active
  `PIF_ASSERT(a_phase_range, clk_i, rst_ni, (state_q == S_IDLE) || (state_q == S_CLEAR) || (INTERP_W'(p_q) < l_eff))

endmodule

>>> src/pif_dp.sv
// Datapath: tap and delay stores, MAC pipeline, rounding and output register.
module pif_dp #(
  parameter int unsigned MAX_TAPS     = pif_pkg::DEF_MAX_TAPS,
  parameter int unsigned MAX_INTERP   = pif_pkg::DEF_MAX_INTERP,
  parameter int unsigned SAMPLE_WIDTH = pif_pkg::DEF_SAMPLE_W,
  localparam int unsigned TIW  = $clog2(MAX_TAPS),
  localparam int unsigned PH_W = $clog2(MAX_INTERP)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pif_pkg::cmd_t              cmd_i,
  input  logic [TIW-1:0]             cmd_addr_i,
  input  logic [TIW-1:0]             cmd_koff_i,
  input  logic [PH_W-1:0]            cmd_phase_i,
  input  logic [SAMPLE_WIDTH-1:0]    sample_i,
  input  logic [TIW-1:0]             tap_idx_i,
  input  logic [pif_pkg::COEF_W-1:0] tap_val_i,
  output logic                       out_free_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [SAMPLE_WIDTH-1:0]    out_sample_o,
  output logic [PH_W-1:0]            out_phase_o,
  output logic                       out_last_o
);

  import pif_pkg::*;

  localparam int unsigned PROD_W = SAMPLE_WIDTH + COEF_W;
  localparam int unsigned ACC_W  = PROD_W + $clog2(MAX_TAPS);
  localparam logic signed [ACC_W:0] RND_HALF = (ACC_W+1)'(1 << (COEF_FRAC - 1));
  localparam logic signed [ACC_W:0] SAT_HI   = (ACC_W+1)'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [ACC_W:0] SAT_LO   = -SAT_HI - (ACC_W+1)'(1);

  logic [TIW-1:0]             wp_q, wp_next;
  logic [TIW:0]               slot_diff;
  logic [TIW-1:0]             slot;
  logic                       tap_ok;
  logic                       dl_we, tp_we;
  logic [TIW-1:0]             dl_waddr, tp_waddr;
  logic [SAMPLE_WIDTH-1:0]    dl_wdata, dl_rdata;
  logic [COEF_W-1:0]          tp_wdata, tp_rdata;
  logic                       iss1_q, iss2_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [ACC_W:0]      rnd;
  logic signed [ACC_W:0]      scaled;
  logic [SAMPLE_WIDTH-1:0]    sat;
  logic                       out_valid_q;
  logic [SAMPLE_WIDTH-1:0]    out_sample_q;
  logic [PH_W-1:0]            out_phase_q;
  logic                       out_last_q;

  // Write pointer marks the slot of the newest sample
  assign wp_next = (wp_q == TIW'(MAX_TAPS - 1)) ? '0 : wp_q + TIW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
    end else if (cmd_i.smp_we) begin
      wp_q <= wp_next;
    end
  end

  // Slot of x[n-k], wrapping around the circular line
  assign slot_diff = {1'b0, wp_q} - {1'b0, cmd_koff_i};
  assign slot      = slot_diff[TIW] ? TIW'(slot_diff + (TIW+1)'(MAX_TAPS))
                                    : slot_diff[TIW-1:0];

  // Store write ports: clearing pass or item writes
  assign tap_ok   = (TIW+1)'(tap_idx_i) < (TIW+1)'(MAX_TAPS);
  assign dl_we    = cmd_i.clear_en || cmd_i.smp_we;
  assign dl_waddr = cmd_i.clear_en ? cmd_addr_i : wp_next;
  assign dl_wdata = cmd_i.clear_en ? '0 : sample_i;
  assign tp_we    = cmd_i.clear_en || (cmd_i.tap_we && tap_ok);
  assign tp_waddr = cmd_i.clear_en ? cmd_addr_i : tap_idx_i;
  assign tp_wdata = cmd_i.clear_en ? '0 : tap_val_i;

  pif_ram #(
    .WIDTH(SAMPLE_WIDTH),
    .DEPTH(MAX_TAPS)
  ) u_delay_ram (
    .clk_i  (clk_i),
    .we_i   (dl_we),
    .waddr_i(dl_waddr),
    .wdata_i(dl_wdata),
    .raddr_i(slot),
    .rdata_o(dl_rdata)
  );

  pif_ram #(
    .WIDTH(COEF_W),
    .DEPTH(MAX_TAPS)
  ) u_tap_ram (
    .clk_i  (clk_i),
    .we_i   (tp_we),
    .waddr_i(tp_waddr),
    .wdata_i(tp_wdata),
    .raddr_i(cmd_addr_i),
    .rdata_o(tp_rdata)
  );

  // MAC pipe: read, multiply, accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss1_q <= 1'b0;
      iss2_q <= 1'b0;
    end else begin
      iss1_q <= cmd_i.issue;
      iss2_q <= iss1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (iss1_q) begin
      prod_q <= PROD_W'($signed(tp_rdata)) * PROD_W'($signed(dl_rdata));
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (iss2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Round half up, drop fraction bits, saturate
  assign rnd    = (ACC_W+1)'(acc_q) + RND_HALF;
  assign scaled = rnd >>> COEF_FRAC;
  assign sat    = (scaled > SAT_HI) ? SAT_HI[SAMPLE_WIDTH-1:0] :
                  (scaled < SAT_LO) ? SAT_LO[SAMPLE_WIDTH-1:0] :
                  scaled[SAMPLE_WIDTH-1:0];

  // Output register
  assign out_free_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_sample_q <= sat;
      out_phase_q  <= cmd_phase_i;
      out_last_q   <= cmd_i.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign out_phase_o  = out_phase_q;
  assign out_last_o   = out_last_q;

endmodule

>>> src/polyphase_interpolating_fir.sv
// A sample word gives L results; phase p sums the taps whose index is p plus a multiple of L,
// below tap_count, and all phases run on one shared multiply-accumulate.
// A tap-write word gives no result.
// Results wait in an output register, so the next word is taken once the run ends.
// Reset (rst_ni low, asynchronous): config returns to L = 1, tap_count = 1, pointer 0,
// then a clearing pass zeroes every entry of both stores; no word is taken meanwhile.
module polyphase_interpolating_fir #(
  parameter int unsigned MAX_TAPS     = pif_pkg::DEF_MAX_TAPS,
  parameter int unsigned MAX_INTERP   = pif_pkg::DEF_MAX_INTERP,
  parameter int unsigned SAMPLE_WIDTH = pif_pkg::DEF_SAMPLE_W,
  localparam int unsigned TIW   = $clog2(MAX_TAPS),
  localparam int unsigned PH_W  = $clog2(MAX_INTERP),
  localparam int unsigned IN_W  = ((SAMPLE_WIDTH + TIW + pif_pkg::COEF_W + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int unsigned CFG_W = pif_pkg::cfg_width(MAX_TAPS, MAX_INTERP)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [IN_W-1:0]                s_axis_tdata,  // sample_in, tap_index, tap_value
  input  logic                           s_axis_tuser,  // req_type
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [OUT_W-1:0]               m_axis_tdata,  // sample_out
  output logic [PH_W-1:0]                m_axis_tuser,  // phase
  output logic                           m_axis_tlast,  // last_of_run
  // config writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pif_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]               cfg_wdata_i
);

  import pif_pkg::*;

  cmd_t                    cmd;
  logic [TIW-1:0]          cmd_addr;
  logic [TIW-1:0]          cmd_koff;
  logic [PH_W-1:0]         cmd_phase;
  logic                    out_free;
  logic [SAMPLE_WIDTH-1:0] out_sample;

  pif_ctrl #(
    .MAX_TAPS  (MAX_TAPS),
    .MAX_INTERP(MAX_INTERP)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (req_e'(s_axis_tuser)),
    .in_ready_o (s_axis_tready),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .out_free_i (out_free),
    .cmd_o      (cmd),
    .cmd_addr_o (cmd_addr),
    .cmd_koff_o (cmd_koff),
    .cmd_phase_o(cmd_phase)
  );

  pif_dp #(
    .MAX_TAPS    (MAX_TAPS),
    .MAX_INTERP  (MAX_INTERP),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_addr_i  (cmd_addr),
    .cmd_koff_i  (cmd_koff),
    .cmd_phase_i (cmd_phase),
    .sample_i    (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .tap_idx_i   (s_axis_tdata[SAMPLE_WIDTH+TIW-1:SAMPLE_WIDTH]),
    .tap_val_i   (s_axis_tdata[SAMPLE_WIDTH+TIW+COEF_W-1:SAMPLE_WIDTH+TIW]),
    .out_free_o  (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_sample_o(out_sample),
    .out_phase_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  // zero fill up to whole bytes
  assign m_axis_tdata = OUT_W'(out_sample);

endmodule
